### design/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// shared types and widths for the rgb to hsl pixel pipeline
// no dependencies

package rgbhsl_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned Q_W       = 8;
  localparam int unsigned HUE_REM_W = 19;
  localparam int unsigned HUE_DIV_W = 11;
  localparam int unsigned SAT_REM_W = 16;
  localparam int unsigned SAT_DIV_W = 8;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned TDATA_W   = 24;

  // per-stage payload of the two long dividers
  typedef struct packed {
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE_DIV_W-1:0] hue_div;
    logic [Q_W-1:0]       hue_q;
    logic [SAT_REM_W-1:0] sat_rem;
    logic [SAT_DIV_W-1:0] sat_div;
    logic [Q_W-1:0]       sat_q;
    logic [CH_W-1:0]      lit;
  } div_t;

endpackage

### design/rgbhsl_front.sv
`timescale 1ns / 1ps
// two front stages: max/min/sector, then hue numerator and divider operands
// depends on rgbhsl_pkg

module rgbhsl_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [rgbhsl_pkg::CH_W-1:0] red_i,
  input  logic [rgbhsl_pkg::CH_W-1:0] green_i,
  input  logic [rgbhsl_pkg::CH_W-1:0] blue_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output rgbhsl_pkg::div_t         data_o
);
  import rgbhsl_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // stage 1
  logic            s1_vld_q;
  logic            s1_rdy;
  sector_e         s1_sec_d, s1_sec_q;
  logic [CH_W-1:0] s1_d_d, s1_d_q;
  logic [CH_W:0]   s1_sum_d, s1_sum_q;
  logic [CH_W-1:0] s1_a_d, s1_a_q;
  logic [CH_W-1:0] s1_b_d, s1_b_q;
  logic [CH_W-1:0] mx, mn;

  // stage 2
  logic            s2_vld_q;
  logic            s2_rdy;
  div_t            s2_d, s2_q;

  logic [HUE_DIV_W-1:0] six_d;
  logic [HUE_DIV_W-1:0] base;
  logic [HUE_DIV_W:0]   num12;
  logic [HUE_DIV_W-1:0] num;
  logic [CH_W:0]        den9;

  assign s2_rdy  = !s2_vld_q || ready_i;
  assign s1_rdy  = !s1_vld_q || s2_rdy;
  assign ready_o = s1_rdy;
  assign valid_o = s2_vld_q;
  assign data_o  = s2_q;

  always_comb begin
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      s1_sec_d = SEC_RED;
      mx       = red_i;
      s1_a_d   = green_i;
      s1_b_d   = blue_i;
    end else if (green_i >= blue_i) begin
      s1_sec_d = SEC_GREEN;
      mx       = green_i;
      s1_a_d   = blue_i;
      s1_b_d   = red_i;
    end else begin
      s1_sec_d = SEC_BLUE;
      mx       = blue_i;
      s1_a_d   = red_i;
      s1_b_d   = green_i;
    end
    s1_d_d   = mx - mn;
    s1_sum_d = {1'b0, mx} + {1'b0, mn};
  end

  always_comb begin
    six_d = HUE_DIV_W'({s1_d_q, 2'b00}) + HUE_DIV_W'({s1_d_q, 1'b0});
    case (s1_sec_q)
      SEC_RED:   base = (s1_a_q < s1_b_q) ? six_d : '0;
      SEC_GREEN: base = HUE_DIV_W'({s1_d_q, 1'b0});
      SEC_BLUE:  base = HUE_DIV_W'({s1_d_q, 2'b00});
      default:   base = '0;
    endcase
    num12 = {1'b0, base} + (HUE_DIV_W+1)'(s1_a_q) - (HUE_DIV_W+1)'(s1_b_q);
    num   = num12[HUE_DIV_W-1:0];
    den9  = (s1_sum_q < (CH_W+1)'(255)) ? s1_sum_q : ((CH_W+1)'(510) - s1_sum_q);

    s2_d.hue_q = '0;
    s2_d.sat_q = '0;
    s2_d.lit   = s1_sum_q[CH_W:1];
    if (s1_d_q == '0) begin
      // gray pixel: zero dividends over unit divisors
      s2_d.hue_rem = '0;
      s2_d.hue_div = HUE_DIV_W'(1);
      s2_d.sat_rem = '0;
      s2_d.sat_div = SAT_DIV_W'(1);
    end else begin
      s2_d.hue_rem = HUE_REM_W'({num, 8'h00}) - HUE_REM_W'(num);
      s2_d.hue_div = six_d;
      s2_d.sat_rem = SAT_REM_W'({s1_d_q, 8'h00}) - SAT_REM_W'(s1_d_q);
      s2_d.sat_div = den9[SAT_DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= valid_i;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && valid_i) begin
      s1_sec_q <= s1_sec_d;
      s1_d_q   <= s1_d_d;
      s1_sum_q <= s1_sum_d;
      s1_a_q   <= s1_a_d;
      s1_b_q   <= s1_b_d;
    end
    if (s2_rdy && s1_vld_q) s2_q <= s2_d;
  end

`ifndef SYNTHESIS
  // quotient of the hue division must fit in eight bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (HUE_REM_W+Q_W)'(s2_q.hue_rem) < {s2_q.hue_div, 8'h00})
    else $error("hue dividend exceeds quotient range");
`endif

endmodule

### design/rgbhsl_divstep.sv
`timescale 1ns / 1ps
// one restoring-division stage, one quotient bit for hue and saturation
// depends on rgbhsl_pkg

module rgbhsl_divstep #(
  parameter int unsigned BitIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rgbhsl_pkg::div_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rgbhsl_pkg::div_t data_o
);
  import rgbhsl_pkg::*;

  logic                 vld_q;
  div_t                 data_d, data_q;
  logic [HUE_REM_W:0]   hue_sub;
  logic [SAT_REM_W:0]   sat_sub;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    data_d  = data_i;
    hue_sub = {1'b0, data_i.hue_rem} - ((HUE_REM_W+1)'(data_i.hue_div) << BitIdx);
    sat_sub = {1'b0, data_i.sat_rem} - ((SAT_REM_W+1)'(data_i.sat_div) << BitIdx);
    if (!hue_sub[HUE_REM_W]) begin
      data_d.hue_rem       = hue_sub[HUE_REM_W-1:0];
      data_d.hue_q[BitIdx] = 1'b1;
    end
    if (!sat_sub[SAT_REM_W]) begin
      data_d.sat_rem       = sat_sub[SAT_REM_W-1:0];
      data_d.sat_q[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

`ifndef SYNTHESIS
  // remainders stay below the divisor at this bit weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (HUE_REM_W+1)'(data_q.hue_rem) < ((HUE_REM_W+1)'(data_q.hue_div) << BitIdx))
    else $error("hue remainder out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (SAT_REM_W+1)'(data_q.sat_rem) < ((SAT_REM_W+1)'(data_q.sat_div) << BitIdx))
    else $error("saturation remainder out of range");
`endif

endmodule

### design/rgb_to_hsl_pixel.sv
`timescale 1ns / 1ps
// top level of the rgb to hsl pixel converter
// depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_divstep

// Converts one 8-bit RGB pixel per transaction into 8-bit hue, saturation and
// lightness with exact integer floor arithmetic. The pipeline takes one pixel
// every clock unless the output stalls. Two front stages find max, min and
// the hue sector, then hue numerator and divider operands; eight restoring
// divider stages produce one quotient bit each for hue and saturation in
// parallel. Every stage has its own valid bit and holds under backpressure,
// so empty slots fill while the output waits; no configuration, no other state.

module rgb_to_hsl_pixel (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rgbhsl_pkg::TDATA_W-1:0]   s_axis_tdata,  // red, green, blue
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rgbhsl_pkg::TDATA_W-1:0]   m_axis_tdata   // hue, saturation, lightness
);
  import rgbhsl_pkg::*;

  logic stg_vld [DIV_STEPS+1];
  logic stg_rdy [DIV_STEPS+1];
  div_t stg_data [DIV_STEPS+1];

  rgbhsl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[CH_W-1:0]),
    .green_i (s_axis_tdata[2*CH_W-1:CH_W]),
    .blue_i  (s_axis_tdata[3*CH_W-1:2*CH_W]),
    .valid_o (stg_vld[0]),
    .ready_i (stg_rdy[0]),
    .data_o  (stg_data[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rgbhsl_divstep #(
      .BitIdx (DIV_STEPS - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[k]),
      .ready_o (stg_rdy[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_vld[k+1]),
      .ready_i (stg_rdy[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  assign stg_rdy[DIV_STEPS] = m_axis_tready;
  assign m_axis_tvalid      = stg_vld[DIV_STEPS];
  assign m_axis_tdata       = {stg_data[DIV_STEPS].lit,
                               stg_data[DIV_STEPS].sat_q,
                               stg_data[DIV_STEPS].hue_q};

`ifndef SYNTHESIS
  // an empty output slot means every stage can advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  // zero saturation only for gray pixels, which have zero hue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2*CH_W-1:CH_W] == '0) |-> m_axis_tdata[CH_W-1:0] == '0)
    else $error("nonzero hue on gray pixel");
`endif

endmodule

### test/tb_rgb_to_hsl_pixel.sv
`timescale 1ns / 1ps
// testbench for rgb_to_hsl_pixel: streams rgb pixels in, checks hue, saturation, lightness
// depends on rgbhsl_pkg and rgb_to_hsl_pixel

module tb_rgb_to_hsl_pixel;

  import rgbhsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 265;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned HOLD_ITEMS   = 40;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [7:0] lightness;
    logic [7:0] saturation;
    logic [7:0] hue;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t        expected_hsl[$];
    int unsigned mismatches;
    int unsigned n_pixels;
    int unsigned n_gray;
    int unsigned n_wrap;
    int unsigned n_sector[3];

    function logic [7:0] clamp_byte(int unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function hsl_t convert(rgb_t px);
      int unsigned r, g, b, mx, mn, d, sum, den, num;
      hsl_t o;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      o.lightness = clamp_byte(sum >> 1);
      if (d == 0) begin
        o.hue = '0;
        o.saturation = '0;
        n_gray++;
      end else begin
        den = (sum < 255) ? sum : 510 - sum;
        o.saturation = clamp_byte((den != 0) ? (255 * d) / den : 255);
        // red sector wraps past a full turn when green is below blue
        if (mx == r) begin
          if (g >= b) begin
            num = g - b;
          end else begin
            num = 6 * d - (b - g);
            n_wrap++;
          end
          n_sector[0]++;
        end else if (mx == g) begin
          num = 2 * d + b - r;
          n_sector[1]++;
        end else begin
          num = 4 * d + r - g;
          n_sector[2]++;
        end
        o.hue = clamp_byte((255 * num) / (6 * d));
      end
      return o;
    endfunction

    function void note_pixel(rgb_t px);
      n_pixels++;
      expected_hsl.push_back(convert(px));
    endfunction

    function void check_hsl(hsl_t got);
      string       field_name[3];
      logic [23:0] e;
      logic [23:0] a;
      field_name = '{"hue", "saturation", "lightness"};
      if (expected_hsl.size() == 0) begin
        mismatches++;
        $display("%0d ns: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      e = expected_hsl.pop_front();
      a = got;
      for (int i = 0; i < 3; i++) begin
        if (e[i*8 +: 8] !== a[i*8 +: 8]) begin
          mismatches++;
          $display("%0d ns: %s expected %0d actual %0d", $time, field_name[i],
                   e[i*8 +: 8], a[i*8 +: 8]);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hsl.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // red, green, blue
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // hue, saturation, lightness

  hsl_scoreboard sb;
  int unsigned   gap_pct;
  int unsigned   stall_pct;
  int unsigned   hold_left;
  int unsigned   cycle_count;

  rgb_to_hsl_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_hsl(m_axis_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic rgb_t pix(int unsigned r, int unsigned g, int unsigned b);
    rgb_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    return p;
  endfunction

  function automatic rgb_t random_pixel();
    int unsigned v[3];
    int unsigned edges[6];
    int unsigned hi, lo, tmp, j;
    edges = '{0, 1, 127, 128, 254, 255};
    case ($urandom_range(9))
      4: begin
        v[0] = $urandom_range(255);
        v[1] = v[0];
        v[2] = v[0];
      end
      5: begin
        v[0] = $urandom_range(255);
        v[1] = v[0];
        v[2] = $urandom_range(v[0]);
      end
      6: begin
        for (int i = 0; i < 3; i++) v[i] = edges[$urandom_range(5)];
      end
      7: begin
        // max plus min close to the saturation breakpoint
        hi = $urandom_range(255, 128);
        tmp = $urandom_range(257, 253);
        lo = (tmp > hi) ? tmp - hi : 0;
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
        v[0] = hi;
        v[1] = lo;
        v[2] = lo + $urandom_range(hi - lo);
      end
      8: begin
        v[0] = $urandom_range(252);
        v[1] = v[0] + $urandom_range(3);
        v[2] = v[0] + $urandom_range(3);
      end
      default: begin
        for (int i = 0; i < 3; i++) v[i] = $urandom_range(255);
      end
    endcase
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = v[i];
      v[i] = v[j];
      v[j] = tmp;
    end
    return pix(v[0], v[1], v[2]);
  endfunction

  // called and returns at a falling edge
  task automatic send_pixel(rgb_t px);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned gap_tbl[4];
    int unsigned stall_tbl[4];
    gap_tbl = '{0, 46, 0, 6};
    stall_tbl = '{0, 0, 46, 6};
    sb = new();
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners, primaries, ties, red wrap, saturation breakpoint
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(255, 255, 255));
    send_pixel(pix(128, 128, 128));
    send_pixel(pix(255, 0, 0));
    send_pixel(pix(0, 255, 0));
    send_pixel(pix(0, 0, 255));
    send_pixel(pix(255, 255, 0));
    send_pixel(pix(0, 255, 255));
    send_pixel(pix(255, 0, 255));
    send_pixel(pix(200, 200, 50));
    send_pixel(pix(50, 200, 200));
    send_pixel(pix(200, 50, 200));
    send_pixel(pix(255, 0, 1));
    send_pixel(pix(255, 10, 200));
    send_pixel(pix(200, 100, 27));
    send_pixel(pix(200, 100, 55));
    send_pixel(pix(200, 100, 56));
    send_pixel(pix(1, 0, 0));
    send_pixel(pix(254, 255, 255));
    send_pixel(pix(255, 254, 254));
    send_pixel(pix(0, 1, 1));
    send_pixel(pix(170, 85, 0));

    // long output hold-off while the input keeps streaming
    hold_left = HOLD_CYCLES;
    repeat (HOLD_ITEMS) send_pixel(random_pixel());

    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_tbl[p];
      stall_pct = stall_tbl[p];
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("converted %0d pixels: %0d gray, sectors red/green/blue %0d/%0d/%0d",
             sb.n_pixels, sb.n_gray, sb.n_sector[0], sb.n_sector[1], sb.n_sector[2]);
    $display("%0d red hues wrapped, with random gaps, stalls and one long hold-off",
             sb.n_wrap);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
